FILE: sv/bfsp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the shortest-path block.
`default_nettype none
package bfsp_pkg;

  localparam int MAX_NODES   = 32;
  localparam int MAX_EDGES   = 256;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int EADDR_W     = $clog2(MAX_EDGES);
  localparam int ETOT_W      = EADDR_W + 1;
  localparam int CNT_W       = NODE_W + 1;
  localparam int DIST_W      = 33;
  localparam int OUT_DIST_W  = 32;
  localparam int EDGE_W      = 2 * NODE_W + WEIGHT_BITS;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_PATH    = 2'd0;
  localparam logic [1:0] ST_NEGCYC  = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_FETCH,
    S_RELAX,
    S_RESOLVE,
    S_WALK,
    S_WALK_RD,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               solve_init;
    logic               add_edge;
    logic               clear_edges;
    logic               edge_rd;
    logic [EADDR_W-1:0] edge_addr;
    logic               dist_rd;
    logic               relax_wr;
    logic               resolve;
    logic               walk_wr;
    logic               walk_next;
    logic [NODE_W-1:0]  buf_waddr;
    logic               emit_rd;
    logic [NODE_W-1:0]  buf_raddr;
    logic               emit;
    logic [1:0]         emit_status;
    logic               emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [ETOT_W-1:0] edge_total;
    logic [CNT_W-1:0]  n_eff;
    logic              improve;
    logic              dst_unreach;
    logic              pred_none;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/bfsp_datapath.sv
// Datapath: edge store, distance and predecessor memories, path buffer and result register.
`default_nettype none
module bfsp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bfsp_pkg::dp_cmd_t             cmd,
  output bfsp_pkg::dp_stat_t                 stat,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bfsp_pkg::CNT_W-1:0]    cfg_wr_data,
  input  wire logic [bfsp_pkg::NODE_W-1:0]   edge_from,
  input  wire logic [bfsp_pkg::NODE_W-1:0]   edge_to,
  input  wire logic signed [bfsp_pkg::WEIGHT_BITS-1:0] edge_weight,
  input  wire logic [bfsp_pkg::NODE_W-1:0]   source_node,
  input  wire logic [bfsp_pkg::NODE_W-1:0]   dest_node,
  output logic                               result_valid,
  output logic [1:0]                         status,
  output logic [bfsp_pkg::NODE_W-1:0]        path_node,
  output logic signed [bfsp_pkg::OUT_DIST_W-1:0] distance,
  output logic                               last_result
);
  import bfsp_pkg::*;

  logic [CNT_W-1:0]  node_count;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_q;
  logic [NODE_W-1:0] dst_q;
  logic [ETOT_W-1:0] edge_total;

  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0] edge_q;
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [DIST_W-1:0] da_q;
  logic [DIST_W-1:0] db_q;
  logic [NODE_W-1:0] pred_mem [MAX_NODES];
  logic [NODE_W-1:0] pred_q;
  logic [NODE_W-1:0] path_mem [MAX_NODES];
  logic [NODE_W-1:0] path_q;
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] pred_valid;
  logic [NODE_W-1:0] node;

  logic [NODE_W-1:0]      ef;
  logic [NODE_W-1:0]      et;
  logic signed [WEIGHT_BITS-1:0] ew;
  logic signed [DIST_W:0] sum;
  logic signed [DIST_W-1:0] nd;
  logic              src_ok;
  logic [OUT_DIST_W-1:0] dist_sat;

  assign ef = edge_q[NODE_W-1:0];
  assign et = edge_q[2*NODE_W-1:NODE_W];
  assign ew = edge_q[EDGE_W-1:2*NODE_W];

  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign src_ok = {1'b0, source_node} < n_eff;

  // Saturating relaxed distance in the 33-bit signed range.
  always_comb begin
    sum = $signed({da_q[DIST_W-1], da_q}) + (DIST_W+1)'(ew);
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      nd = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      nd = sum[DIST_W-1:0];
    end
  end

  always_comb begin
    if (da_q[DIST_W-1] != da_q[OUT_DIST_W-1]) begin
      dist_sat = da_q[DIST_W-1] ? {1'b1, {(OUT_DIST_W-1){1'b0}}}
                                : {1'b0, {(OUT_DIST_W-1){1'b1}}};
    end else begin
      dist_sat = da_q[OUT_DIST_W-1:0];
    end
  end

  assign stat.edge_total  = edge_total;
  assign stat.n_eff       = n_q;
  assign stat.improve     = ({1'b0, ef} < n_q) && ({1'b0, et} < n_q) && reached[ef] &&
                            (!reached[et] || (nd < $signed(db_q)));
  assign stat.dst_unreach = ({1'b0, dst_q} >= n_q) || !reached[dst_q];
  assign stat.pred_none   = !pred_valid[node];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      edge_total <= '0;
      reached    <= '0;
      pred_valid <= '0;
      n_q        <= NODE_COUNT_RESET;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (cmd.clear_edges) begin
        edge_total <= '0;
      end else if (cmd.add_edge && (edge_total < ETOT_W'(MAX_EDGES))) begin
        edge_total <= edge_total + ETOT_W'(1);
      end
      if (cmd.solve_init) begin
        n_q        <= n_eff;
        pred_valid <= '0;
        reached    <= src_ok ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << source_node) : '0;
      end else if (cmd.relax_wr) begin
        reached[et]    <= 1'b1;
        pred_valid[et] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_edge && (edge_total < ETOT_W'(MAX_EDGES))) begin
      edge_mem[edge_total[EADDR_W-1:0]] <= {edge_weight, edge_to, edge_from};
    end
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[cmd.edge_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.solve_init) begin
      dist_mem[source_node] <= '0;
      dst_q <= dest_node;
    end else if (cmd.relax_wr) begin
      dist_mem[et] <= nd;
    end
    if (cmd.dist_rd) begin
      da_q <= dist_mem[ef];
      db_q <= dist_mem[et];
    end else if (cmd.resolve) begin
      da_q <= dist_mem[dst_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.relax_wr) begin
      pred_mem[et] <= ef;
    end
    if (cmd.walk_wr) begin
      pred_q <= pred_mem[node];
    end
    if (cmd.resolve) begin
      node <= dst_q;
    end else if (cmd.walk_next) begin
      node <= pred_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_wr) begin
      path_mem[cmd.buf_waddr] <= node;
    end
    if (cmd.emit_rd) begin
      path_q <= path_mem[cmd.buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      last_result <= cmd.emit_last;
      case (cmd.emit_status)
        ST_PATH: begin
          path_node <= path_q;
          distance  <= cmd.emit_last ? dist_sat : '0;
        end
        ST_UNREACH: begin
          path_node <= dst_q;
          distance  <= '0;
        end
        default: begin
          path_node <= '0;
          distance  <= '0;
        end
      endcase
    end
  end

  initial_check_dummy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.emit))
    else $error("result beat without an emit command");

  assert property (@(posedge clk) disable iff (rst)
    cmd.relax_wr |-> stat.improve)
    else $error("distance written without an improvement");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_status == ST_PATH && cmd.emit_last) |->
    reached[dst_q])
    else $error("path reported to an unreached destination");

endmodule
`default_nettype wire

FILE: sv/bfsp_ctrl.sv
// Controller: sequences relaxation passes, the negative-cycle check, path walk and result beats.
`default_nettype none
module bfsp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          command,
  output logic                     busy,
  output bfsp_pkg::dp_cmd_t        cmd,
  input  wire bfsp_pkg::dp_stat_t  stat
);
  import bfsp_pkg::*;

  state_t            state, state_next;
  logic [ETOT_W-1:0] e, e_next;
  logic [CNT_W-1:0]  pass, pass_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  i, i_next;
  logic [CNT_W-1:0]  ridx;

  assign ridx = cnt - CNT_W'(1) - i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      e     <= '0;
      pass  <= '0;
      k     <= '0;
      cnt   <= '0;
      i     <= '0;
    end else begin
      state <= state_next;
      e     <= e_next;
      pass  <= pass_next;
      k     <= k_next;
      cnt   <= cnt_next;
      i     <= i_next;
    end
  end

  always_comb begin
    state_next = state;
    e_next     = e;
    pass_next  = pass;
    k_next     = k;
    cnt_next   = cnt;
    i_next     = i;
    cmd        = '0;
    busy       = (state != S_IDLE);
    cmd.edge_addr = e[EADDR_W-1:0];
    cmd.buf_waddr = k[NODE_W-1:0];
    cmd.buf_raddr = ridx[NODE_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_ADD:   cmd.add_edge = 1'b1;
            CMD_CLEAR: cmd.clear_edges = 1'b1;
            CMD_SOLVE: begin
              cmd.solve_init = 1'b1;
              e_next     = '0;
              pass_next  = '0;
              state_next = S_EDGE;
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        if (e == stat.edge_total) begin
          if (pass == stat.n_eff) begin
            state_next = S_RESOLVE;
          end else begin
            pass_next = pass + CNT_W'(1);
            e_next    = '0;
          end
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.dist_rd = 1'b1;
        state_next  = S_RELAX;
      end
      S_RELAX: begin
        e_next     = e + ETOT_W'(1);
        state_next = S_EDGE;
        if (stat.improve) begin
          if (pass == stat.n_eff) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NEGCYC;
            cmd.emit_last   = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.relax_wr = 1'b1;
          end
        end
      end
      S_RESOLVE: begin
        if (stat.dst_unreach) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_UNREACH;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.resolve = 1'b1;
          k_next      = '0;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_wr = 1'b1;
        if (stat.pred_none || (k + CNT_W'(1) == stat.n_eff)) begin
          cnt_next   = k + CNT_W'(1);
          i_next     = '0;
          state_next = S_EMIT_RD;
        end else begin
          k_next     = k + CNT_W'(1);
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_next = 1'b1;
        state_next    = S_WALK;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_PATH;
        cmd.emit_last   = (i + CNT_W'(1) == cnt);
        if (i + CNT_W'(1) == cnt) begin
          state_next = S_IDLE;
        end else begin
          i_next     = i + CNT_W'(1);
          state_next = S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RELAX) |-> ($past(state) == S_FETCH))
    else $error("relax step without a distance fetch");

  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (pass <= stat.n_eff))
    else $error("pass count ran past the node count");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (i < cnt))
    else $error("emit index beyond path length");

endmodule
`default_nettype wire

FILE: sv/bellman_ford_shortest_path_top.sv
// Top level of the shortest-path engine: controller plus datapath.
//
//  Channel   Handshake               Payload
//  -------   ---------               -------
//  command   start & !busy           command, edge_from, edge_to, edge_weight,
//                                     source_node, dest_node
//  result    result_valid (1 cycle)  status, path_node, distance, last_result
//  config    cfg_wr_en               cfg_wr_data (node_count)
//
// An add or clear beat leaves busy low. A solve runs the N relaxation passes
// plus the check pass: each of the E stored edges takes an edge read, a
// distance read and a compare and write step, and each pass ends with a
// closing step. A negative cycle ends the check pass early. A resolve step
// follows, then the predecessor chain is walked (a write step per path node,
// a read step between nodes) and emitted (a read and an emit step per node);
// each result beat appears in the cycle after its emit step. Reset (rst,
// synchronous) empties the edge store and sets node_count to 32. The receiver
// cannot stall: each result beat appears for exactly one cycle on result_valid.
`default_nettype none
module bellman_ford_shortest_path_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         command,
  input  wire logic [bfsp_pkg::NODE_W-1:0]        edge_from,
  input  wire logic [bfsp_pkg::NODE_W-1:0]        edge_to,
  input  wire logic signed [bfsp_pkg::WEIGHT_BITS-1:0] edge_weight,
  input  wire logic [bfsp_pkg::NODE_W-1:0]        source_node,
  input  wire logic [bfsp_pkg::NODE_W-1:0]        dest_node,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bfsp_pkg::CNT_W-1:0]         cfg_wr_data,
  output logic                                    result_valid,
  output logic [1:0]                              status,
  output logic [bfsp_pkg::NODE_W-1:0]             path_node,
  output logic signed [bfsp_pkg::OUT_DIST_W-1:0]  distance,
  output logic                                    last_result
);
  import bfsp_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the pass, edge and path counters.
  bfsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .cmd     (cmd),
    .stat    (stat)
  );

  // The datapath holds all storage and registers each result beat.
  bfsp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .edge_weight  (edge_weight),
    .source_node  (source_node),
    .dest_node    (dest_node),
    .result_valid (result_valid),
    .status       (status),
    .path_node    (path_node),
    .distance     (distance),
    .last_result  (last_result)
  );

endmodule
`default_nettype wire
